// ===== hdl/rmq_pkg.sv =====
// types and constants shared by the rotation matrix to quaternion pipeline
// no dependencies
`timescale 1ns / 1ps

package rmq_pkg;

  // fixed-point formats
  localparam int DATA_W = 32;            // Q2.30 element and component width
  localparam int WIDE_W = 35;            // trace and square-root argument width
  localparam int MAG_W  = 33;            // magnitude of a sum or difference of two elements
  localparam int RAD_W  = 64;            // radicand width (argument shifted up by 30)
  localparam int ROOT_W = 32;            // square root width
  localparam int NUM_W  = 62;            // dividend width (magnitude shifted up by 29)
  localparam int QUO_W  = 33;            // quotient bits kept before saturation
  localparam int FRAC_W = 30;

  localparam logic signed [WIDE_W-1:0] ONE_Q30 = WIDE_W'(64'sd1073741824);
  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(64'd2147483647);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(64'd2147483648);

  // which quaternion component comes straight from the square root
  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2,
    COMP_W = 2'd3
  } comp_t;

  // per-item side data that travels through the root and divide stages
  typedef struct packed {
    logic                       degen;
    comp_t                      big;
    logic [2:0]                 neg;
    logic [2:0][MAG_W-1:0]      mag;
  } item_t;

endpackage

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// rotation matrix to quaternion converter (largest-component method), fully pipelined
// depends on rmq_pkg
`timescale 1ns / 1ps

// Takes one 3x3 matrix per clock whenever start is high; busy is never raised. Every matrix
// gives exactly one quaternion, shown for one cycle with done high; results leave in the
// order the matrices came in and cannot be held off. On the way, each matrix passes through
// trace, branch and argument set-up registers, 32 square-root stages (one root bit each),
// a dividend register, 33 restoring-divide stages (three dividers side by side, one
// quotient bit each) and one output register.
module rotation_matrix_to_quaternion (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] m00,
  input  logic signed [31:0] m01,
  input  logic signed [31:0] m02,
  input  logic signed [31:0] m10,
  input  logic signed [31:0] m11,
  input  logic signed [31:0] m12,
  input  logic signed [31:0] m20,
  input  logic signed [31:0] m21,
  input  logic signed [31:0] m22,
  output logic               done,
  output logic signed [31:0] qx,
  output logic signed [31:0] qy,
  output logic signed [31:0] qz,
  output logic signed [31:0] qw,
  output logic               degenerate
);

  localparam int SQ_STAGES = rmq_pkg::ROOT_W;
  localparam int DV_STAGES = rmq_pkg::QUO_W;
  localparam int LATENCY   = 2 + SQ_STAGES + 1 + DV_STAGES + 1;

  // never stalls
  assign busy = 1'b0;

  // stage 1: trace, candidate arguments, off-diagonal sums and differences
  logic signed [rmq_pkg::WIDE_W-1:0] e00, e11, e22, tr_c;
  logic [1:0] sel_c;

  assign e00  = rmq_pkg::WIDE_W'(m00);
  assign e11  = rmq_pkg::WIDE_W'(m11);
  assign e22  = rmq_pkg::WIDE_W'(m22);
  assign tr_c = e00 + e11 + e22;

  // largest diagonal element, ties to the lower index
  always_comb begin
    sel_c = 2'd0;
    if (m11 > m00) sel_c = 2'd1;
    if (sel_c == 2'd1) begin
      if (m22 > m11) sel_c = 2'd2;
    end else begin
      if (m22 > m00) sel_c = 2'd2;
    end
  end

  logic                              s1_vld;
  logic signed [rmq_pkg::WIDE_W-1:0] s1_tr, s1_at, s1_a0, s1_a1, s1_a2;
  logic signed [rmq_pkg::MAG_W-1:0]  s1_d21, s1_d02, s1_d10, s1_s01, s1_s02, s1_s12;
  logic [1:0]                        s1_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_tr  <= tr_c;
    s1_at  <= tr_c + rmq_pkg::ONE_Q30;
    s1_a0  <= e00 - (e11 + e22) + rmq_pkg::ONE_Q30;
    s1_a1  <= e11 - (e22 + e00) + rmq_pkg::ONE_Q30;
    s1_a2  <= e22 - (e00 + e11) + rmq_pkg::ONE_Q30;
    s1_d21 <= rmq_pkg::MAG_W'(m21) - rmq_pkg::MAG_W'(m12);
    s1_d02 <= rmq_pkg::MAG_W'(m02) - rmq_pkg::MAG_W'(m20);
    s1_d10 <= rmq_pkg::MAG_W'(m10) - rmq_pkg::MAG_W'(m01);
    s1_s01 <= rmq_pkg::MAG_W'(m01) + rmq_pkg::MAG_W'(m10);
    s1_s02 <= rmq_pkg::MAG_W'(m02) + rmq_pkg::MAG_W'(m20);
    s1_s12 <= rmq_pkg::MAG_W'(m12) + rmq_pkg::MAG_W'(m21);
    s1_sel <= sel_c;
  end

  // stage 2: branch choice, radicand and the three dividend magnitudes
  logic signed [rmq_pkg::WIDE_W-1:0] arg_c;
  logic signed [rmq_pkg::MAG_W-1:0]  slot_v [3];
  rmq_pkg::comp_t                    big_c;
  logic                              degen_c;
  rmq_pkg::item_t                    item_c;
  logic [rmq_pkg::RAD_W-1:0]         rad_c;

  always_comb begin
    if (s1_tr > 0) begin
      arg_c     = s1_at;
      big_c     = rmq_pkg::COMP_W;
      slot_v[0] = s1_d21;
      slot_v[1] = s1_d02;
      slot_v[2] = s1_d10;
    end else begin
      case (s1_sel)
        2'd1: begin
          arg_c     = s1_a1;
          big_c     = rmq_pkg::COMP_Y;
          slot_v[0] = s1_d02;
          slot_v[1] = s1_s12;
          slot_v[2] = s1_s01;
        end
        2'd2: begin
          arg_c     = s1_a2;
          big_c     = rmq_pkg::COMP_Z;
          slot_v[0] = s1_d10;
          slot_v[1] = s1_s02;
          slot_v[2] = s1_s12;
        end
        default: begin
          arg_c     = s1_a0;
          big_c     = rmq_pkg::COMP_X;
          slot_v[0] = s1_d21;
          slot_v[1] = s1_s01;
          slot_v[2] = s1_s02;
        end
      endcase
    end
    degen_c      = (s1_tr <= 0) && (arg_c <= 0);
    item_c.degen = degen_c;
    item_c.big   = big_c;
    for (int n = 0; n < 3; n++) begin
      item_c.neg[n] = slot_v[n][rmq_pkg::MAG_W-1];
      item_c.mag[n] = slot_v[n][rmq_pkg::MAG_W-1] ? rmq_pkg::MAG_W'(-slot_v[n])
                                                   : rmq_pkg::MAG_W'(slot_v[n]);
    end
    rad_c = degen_c ? '0
                    : rmq_pkg::RAD_W'({arg_c[rmq_pkg::MAG_W-1:0], {rmq_pkg::FRAC_W{1'b0}}});
  end

  // square-root pipeline, one root bit per stage
  logic                       sq_vld  [0:SQ_STAGES];
  logic [rmq_pkg::RAD_W-1:0]  sq_rem  [0:SQ_STAGES];
  logic [rmq_pkg::ROOT_W-1:0] sq_root [0:SQ_STAGES];
  rmq_pkg::item_t             sq_item [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else begin
      sq_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem[0]  <= rad_c;
    sq_root[0] <= '0;
    sq_item[0] <= item_c;
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    localparam int B = SQ_STAGES - 1 - g;
    logic [rmq_pkg::RAD_W-1:0] trial;
    logic                      fit;

    assign trial = (rmq_pkg::RAD_W'(sq_root[g]) << (B + 1)) | (rmq_pkg::RAD_W'(1) << (2 * B));
    assign fit   = sq_rem[g] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[g+1] <= 1'b0;
      end else begin
        sq_vld[g+1] <= sq_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem[g+1]  <= fit ? sq_rem[g] - trial : sq_rem[g];
      sq_root[g+1] <= sq_root[g] | (fit ? rmq_pkg::ROOT_W'(1) << B : '0);
      sq_item[g+1] <= sq_item[g];
    end
  end

  // divide pipeline, three restoring dividers, one quotient bit per stage
  logic                       dv_vld  [0:DV_STAGES];
  logic [rmq_pkg::ROOT_W-1:0] dv_s    [0:DV_STAGES];
  logic                       dv_hi   [0:DV_STAGES][3];
  logic [rmq_pkg::NUM_W-1:0]  dv_rem  [0:DV_STAGES][3];
  logic [rmq_pkg::QUO_W-1:0]  dv_q    [0:DV_STAGES][3];
  rmq_pkg::item_t             dv_item [0:DV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= sq_vld[SQ_STAGES];
    end
  end

  // dividends and the quotient-overflow check (quotient at or above 2^33)
  logic [rmq_pkg::NUM_W-1:0] num_c [3];
  for (genvar n = 0; n < 3; n++) begin : g_num
    assign num_c[n] = {sq_item[SQ_STAGES].mag[n], 29'b0};

    always_ff @(posedge clk) begin
      dv_rem[0][n] <= num_c[n];
      dv_q[0][n]   <= '0;
      dv_hi[0][n]  <= rmq_pkg::ROOT_W'(num_c[n][rmq_pkg::NUM_W-1:rmq_pkg::QUO_W])
                      >= sq_root[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    dv_s[0]    <= sq_root[SQ_STAGES];
    dv_item[0] <= sq_item[SQ_STAGES];
  end

  for (genvar g = 0; g < DV_STAGES; g++) begin : g_div
    localparam int B = DV_STAGES - 1 - g;
    logic [rmq_pkg::RAD_W-1:0] dsh;

    assign dsh = rmq_pkg::RAD_W'(dv_s[g]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[g+1] <= 1'b0;
      end else begin
        dv_vld[g+1] <= dv_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      dv_s[g+1]    <= dv_s[g];
      dv_hi[g+1]   <= dv_hi[g];
      dv_item[g+1] <= dv_item[g];
    end

    for (genvar n = 0; n < 3; n++) begin : g_lane
      logic fit;
      assign fit = rmq_pkg::RAD_W'(dv_rem[g][n]) >= dsh;

      always_ff @(posedge clk) begin
        dv_rem[g+1][n] <= fit ? rmq_pkg::NUM_W'(rmq_pkg::RAD_W'(dv_rem[g][n]) - dsh)
                              : dv_rem[g][n];
        dv_q[g+1][n]   <= dv_q[g][n] | (fit ? rmq_pkg::QUO_W'(1) << B : '0);
      end
    end
  end

  // saturation, sign and component placement
  logic [31:0]    slot_r [3];
  logic [31:0]    big_r;
  logic [31:0]    qx_c, qy_c, qz_c, qw_c;
  rmq_pkg::item_t fin;

  assign fin   = dv_item[DV_STAGES];
  assign big_r = 32'(dv_s[DV_STAGES] >> 1);

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      if (fin.neg[n]) begin
        if (dv_hi[DV_STAGES][n] || dv_q[DV_STAGES][n] > rmq_pkg::NEG_LIMIT) begin
          slot_r[n] = 32'h8000_0000;
        end else begin
          slot_r[n] = 32'(-dv_q[DV_STAGES][n]);
        end
      end else begin
        if (dv_hi[DV_STAGES][n] || dv_q[DV_STAGES][n] > rmq_pkg::POS_LIMIT) begin
          slot_r[n] = 32'h7fff_ffff;
        end else begin
          slot_r[n] = 32'(dv_q[DV_STAGES][n]);
        end
      end
    end
    case (fin.big)
      rmq_pkg::COMP_X: begin
        qx_c = big_r;     qy_c = slot_r[1]; qz_c = slot_r[2]; qw_c = slot_r[0];
      end
      rmq_pkg::COMP_Y: begin
        qx_c = slot_r[2]; qy_c = big_r;     qz_c = slot_r[1]; qw_c = slot_r[0];
      end
      rmq_pkg::COMP_Z: begin
        qx_c = slot_r[1]; qy_c = slot_r[2]; qz_c = big_r;     qw_c = slot_r[0];
      end
      default: begin
        qx_c = slot_r[0]; qy_c = slot_r[1]; qz_c = slot_r[2]; qw_c = big_r;
      end
    endcase
    if (fin.degen) begin
      qx_c = '0;
      qy_c = '0;
      qz_c = '0;
      qw_c = '0;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[DV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    qx         <= qx_c;
    qy         <= qy_c;
    qz         <= qz_c;
    qw         <= qw_c;
    degenerate <= fin.degen;
  end

  // every result traces back to an earlier input transfer
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input transfer");

  // integer square root leaves a remainder no larger than twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    sq_vld[SQ_STAGES] |-> sq_rem[SQ_STAGES] <= {31'b0, sq_root[SQ_STAGES], 1'b0})
    else $error("square root remainder out of range");

  // a degenerate result carries an all-zero quaternion
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (qx == 0 && qy == 0 && qz == 0 && qw == 0))
    else $error("degenerate result with nonzero components");

endmodule
